// ----- rtl/gent_pkg.sv -----
`default_nettype none

package gent_pkg;

    localparam int OP_W   = 3;
    localparam int SLOT_W = 10;
    localparam int GEN_W  = 16;
    localparam int CID_W  = 6;
    localparam int MASK_W = 64;
    localparam int RIDX_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 3'd0,
        OP_ALIVE  = 3'd1,
        OP_KILL   = 3'd2,
        OP_HAS1   = 3'd3,
        OP_HASALL = 3'd4,
        OP_SETMAP = 3'd5,
        OP_QUERY  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CHECK = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/gent_ifs.sv -----
`default_nettype none

interface gent_in_if
    import gent_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot_index;
    logic [GEN_W-1:0]  handle_generation;
    logic [CID_W-1:0]  component_id;
    logic [MASK_W-1:0] component_mask;

    modport source (
        output valid, operation, slot_index, handle_generation, component_id,
               component_mask,
        input  ready
    );
    modport sink (
        input  valid, operation, slot_index, handle_generation, component_id,
               component_mask,
        output ready
    );
endinterface

interface gent_out_if
    import gent_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RIDX_W-1:0] result_index;
    logic [GEN_W-1:0]  result_generation;
    logic              answer;
    logic              query_done;
    logic              table_full;

    modport source (
        output valid, result_index, result_generation, answer, query_done,
               table_full,
        input  ready
    );
    modport sink (
        input  valid, result_index, result_generation, answer, query_done,
               table_full,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/generational_entity_table_core.sv -----
`default_nettype none

// Channel  | Dir | Modport | Transaction
// ---------+-----+---------+------------------------------------------------
// i_req    | in  | sink    | operation, slot, handle generation, cid, mask
// o_rsp    | out | source  | index, generation, answer, query done, full
//
// Steps: a table operation is accepted, then evaluated on the registered
//   memory read. A query steps on past each slot that does not match; the
//   scan walks the slot memories one address per cycle.
// Reset: after i_rst_n a clearing pass zeroes the live and bitmap memories,
//   one entry per cycle; i_req.ready stays low meanwhile.
// Stalls: a finished result sits in the output register; the next request
//   is taken while it waits. An item whose result cannot be loaded holds in
//   evaluation and commits its table update only when the result loads.
module generational_entity_table_core
    import gent_pkg::*;
#(
    parameter int MAX_SLOTS       = 1024,
    parameter int COMPONENT_COUNT = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gent_in_if.sink      i_req,
    gent_out_if.source   o_rsp
);

    // memory address, used-count and scan-position widths
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int UW = $clog2(MAX_SLOTS + 1);
    localparam int PW = (UW > SLOT_W + 1) ? UW : SLOT_W + 1;
    localparam int CC = COMPONENT_COUNT;

    localparam logic [UW-1:0]    MAX_U = UW'(MAX_SLOTS);
    localparam logic [PW-1:0]    MAX_P = PW'(MAX_SLOTS);
    localparam logic [PW-1:0]    LAST_P = PW'(MAX_SLOTS - 1);
    localparam logic [GEN_W-1:0] GEN_ONE = GEN_W'(1);

    // Slots are never reused, so a slot's generation moves from 0 to 1 at
    // create and never again: a live slot always carries generation 1.
    // The generation store therefore needs no memory.

    logic            live_mem [MAX_SLOTS];
    logic [CC-1:0]   bits_mem [MAX_SLOTS];

    t_state          r_state, n_state;
    logic [PW-1:0]   r_pos, n_pos;
    logic [UW-1:0]   r_used, n_used;

    t_op             r_op;
    logic [GEN_W-1:0]  r_hgen;
    logic [CID_W-1:0]  r_cid;
    logic [MASK_W-1:0] r_mask;

    logic            r_live_rd;
    logic [CC-1:0]   r_bits_rd;

    logic              r_out_valid;
    logic [RIDX_W-1:0] r_out_idx;
    logic [GEN_W-1:0]  r_out_gen;
    logic              r_out_ans;
    logic              r_out_done;
    logic              r_out_full;

    logic            live_we;
    logic [AW-1:0]   live_wa;
    logic            live_wd;
    logic            bits_we;
    logic [AW-1:0]   bits_wa;
    logic [CC-1:0]   bits_wd;

    logic            accept;
    logic            out_free;
    logic            commit;
    logic            scan_step;
    logic            want_live_we;
    logic            want_bits_we;
    logic            in_range;
    logic            alive;
    logic            covers;
    logic [MASK_W-1:0] have;

    logic              res_load;
    logic [RIDX_W-1:0] c_idx;
    logic [GEN_W-1:0]  c_gen;
    logic              c_ans;
    logic              c_done;
    logic              c_full;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // evaluation of the slot at r_pos from the registered read
    assign in_range = (r_pos < MAX_P);
    assign alive    = in_range && r_live_rd && (r_hgen == GEN_ONE);
    assign have     = MASK_W'(r_bits_rd);
    assign covers   = ((have & r_mask) == r_mask);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_used       = r_used;
        want_live_we = 1'b0;
        want_bits_we = 1'b0;
        live_wa      = r_pos[AW-1:0];
        live_wd      = 1'b0;
        bits_wa      = r_pos[AW-1:0];
        bits_wd      = '0;
        live_we      = 1'b0;
        bits_we      = 1'b0;
        scan_step    = 1'b0;
        commit       = 1'b0;
        res_load     = 1'b0;
        c_idx        = '0;
        c_gen        = '0;
        c_ans        = 1'b0;
        c_done       = 1'b0;
        c_full       = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                live_we = 1'b1;
                bits_we = 1'b1;
                if (r_pos == LAST_P) begin
                    n_state = ST_IDLE;
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + PW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_pos = PW'(i_req.slot_index);
                    if (t_op'(i_req.operation) == OP_QUERY) begin
                        n_pos = PW'(i_req.slot_index) + PW'(1);
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                case (r_op)
                    OP_CREATE: begin
                        if (r_used >= MAX_U) begin
                            c_full = 1'b1;
                        end else begin
                            want_live_we = 1'b1;
                            live_wa      = r_used[AW-1:0];
                            live_wd      = 1'b1;
                            c_idx        = RIDX_W'(r_used);
                            c_gen        = GEN_ONE;
                        end
                    end
                    OP_ALIVE: begin
                        c_ans = alive;
                    end
                    OP_KILL: begin
                        want_live_we = in_range;
                    end
                    OP_HAS1: begin
                        c_ans = alive && (int'(r_cid) < CC) && have[r_cid];
                    end
                    OP_HASALL: begin
                        c_ans = alive && covers;
                    end
                    OP_SETMAP: begin
                        want_bits_we = in_range;
                        bits_wd      = r_mask[CC-1:0];
                    end
                    OP_QUERY: begin
                        // pos < used implies pos is inside the table
                        if (PW'(r_used) > r_pos) begin
                            if (r_live_rd && covers) begin
                                c_idx = RIDX_W'(r_pos);
                                c_gen = GEN_ONE;
                            end else begin
                                scan_step = 1'b1;
                            end
                        end else begin
                            c_idx  = RIDX_W'(r_used);
                            c_done = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                if (scan_step) begin
                    n_pos = r_pos + PW'(1);
                end else if (out_free) begin
                    commit   = 1'b1;
                    res_load = 1'b1;
                    n_state  = ST_IDLE;
                end

                live_we = want_live_we && commit;
                bits_we = want_bits_we && commit;
                if (commit && (r_op == OP_CREATE) && !c_full) begin
                    n_used = r_used + UW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // slot memories: one write port, registered read at the next position
    always_ff @(posedge i_clk) begin
        if (live_we) begin
            live_mem[live_wa] <= live_wd;
        end
        r_live_rd <= live_mem[n_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (bits_we) begin
            bits_mem[bits_wa] <= bits_wd;
        end
        r_bits_rd <= bits_mem[n_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pos       <= '0;
            r_used      <= UW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_used  <= n_used;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_req.operation);
            r_hgen <= i_req.handle_generation;
            r_cid  <= i_req.component_id;
            r_mask <= i_req.component_mask;
        end
        if (res_load) begin
            r_out_idx  <= c_idx;
            r_out_gen  <= c_gen;
            r_out_ans  <= c_ans;
            r_out_done <= c_done;
            r_out_full <= c_full;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.result_index      = r_out_idx;
    assign o_rsp.result_generation = r_out_gen;
    assign o_rsp.answer            = r_out_ans;
    assign o_rsp.query_done        = r_out_done;
    assign o_rsp.table_full        = r_out_full;

endmodule

`default_nettype wire

// ----- tb/sv/generational_entity_table_core_tb.sv -----
`timescale 1ns / 1ps

module generational_entity_table_core_tb
    import gent_pkg::*;
();

    localparam int TABLE_SLOTS = 1024;
    localparam int COMP_COUNT  = 64;

    // Operation code the block does not decode; it must change nothing.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [RIDX_W-1:0] idx;
        logic [GEN_W-1:0]  gen;
        logic              answer;
        logic              done;
        logic              full;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    gent_in_if  req_if ();
    gent_out_if rsp_if ();

    generational_entity_table_core #(
        .MAX_SLOTS       (TABLE_SLOTS),
        .COMPONENT_COUNT (COMP_COUNT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the entity table, advanced at each accepted request.
    bit               slot_live [TABLE_SLOTS];
    bit [GEN_W-1:0]   slot_gen  [TABLE_SLOTS];
    bit [MASK_W-1:0]  slot_map  [TABLE_SLOTS];
    int unsigned      table_used;

    t_rsp expected_q [$];
    t_rsp want;
    int   mismatch_count;
    int   rsp_hold;      // cycles the response side keeps ready low
    bit   no_idle;       // disables random idling on both sides

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [MASK_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic bit handle_live(logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen);
        return slot_live[slot] && (slot_gen[slot] == gen);
    endfunction

    // Expected response for one request; updates the shadow table.
    function automatic t_rsp predict_response(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                              logic [GEN_W-1:0] gen, logic [CID_W-1:0] cid,
                                              logic [MASK_W-1:0] mask);
        t_rsp r;
        int   s;
        bit   hit;
        r = '0;
        case (op)
            OP_CREATE: begin
                if (table_used >= TABLE_SLOTS) begin
                    r.full = 1'b1;
                end else begin
                    s = int'(table_used);
                    slot_live[s] = 1'b1;
                    slot_gen[s]  = slot_gen[s] + 1'b1;
                    table_used   = table_used + 1;
                    r.idx = RIDX_W'(s);
                    r.gen = slot_gen[s];
                end
            end
            OP_ALIVE:  r.answer = handle_live(slot, gen);
            OP_KILL:   slot_live[slot] = 1'b0;
            OP_HAS1:   r.answer = handle_live(slot, gen) && slot_map[slot][cid];
            OP_HASALL: r.answer = handle_live(slot, gen) && ((slot_map[slot] & mask) == mask);
            OP_SETMAP: slot_map[slot] = mask;
            OP_QUERY: begin
                hit = 1'b0;
                for (s = int'(slot) + 1; s < int'(table_used) && s < TABLE_SLOTS; s++) begin
                    if (!hit && slot_live[s] && ((slot_map[s] & mask) == mask)) begin
                        hit   = 1'b1;
                        r.idx = RIDX_W'(s);
                        r.gen = slot_gen[s];
                    end
                end
                if (!hit) begin
                    r.idx  = RIDX_W'(table_used);
                    r.done = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, exp_v, got_v, $realtime);
        mismatch_count++;
    endtask

    // Response monitor: every accepted transaction is checked against the oldest
    // outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("response with none outstanding", 64'd0,
                                64'(rsp_if.result_index));
            end else begin
                want = expected_q.pop_front();
                if (rsp_if.result_index !== want.idx)
                    report_mismatch("result_index", 64'(want.idx), 64'(rsp_if.result_index));
                if (rsp_if.result_generation !== want.gen)
                    report_mismatch("result_generation", 64'(want.gen),
                                    64'(rsp_if.result_generation));
                if (rsp_if.answer !== want.answer)
                    report_mismatch("answer", 64'(want.answer), 64'(rsp_if.answer));
                if (rsp_if.query_done !== want.done)
                    report_mismatch("query_done", 64'(want.done), 64'(rsp_if.query_done));
                if (rsp_if.table_full !== want.full)
                    report_mismatch("table_full", 64'(want.full), 64'(rsp_if.table_full));
            end
        end
    end

    // Response-side ready: random stalls, or a counted hold-off when requested.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold > 0) begin
                rsp_if.ready <= 1'b0;
                rsp_hold = rsp_hold - 1;
            end else begin
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 9);
            end
        end
    end

    // One request transaction. Valid is left high after acceptance; the next
    // call or lower_request decides what it does at the following falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                input logic [GEN_W-1:0] gen, input logic [CID_W-1:0] cid,
                                input logic [MASK_W-1:0] mask);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 9) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid             <= 1'b1;
        req_if.operation         <= op;
        req_if.slot_index        <= slot;
        req_if.handle_generation <= gen;
        req_if.component_id      <= cid;
        req_if.component_mask    <= mask;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        expected_q.push_back(predict_response(op, slot, gen, cid, mask));
    endtask

    task automatic lower_request();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    // Sender pauses until every outstanding response has come back.
    task automatic wait_drain();
        lower_request();
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot();
        if (table_used > 1 && $urandom_range(99) < 85)
            return SLOT_W'($urandom_range(table_used - 1, 1));
        return SLOT_W'($urandom_range(TABLE_SLOTS - 1, 0));
    endfunction

    // Mostly well-formed traffic: handles of created slots with their real
    // generation, masks taken from stored bitmaps; the rest is noise.
    task automatic random_request();
        int                unsigned pick;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic [CID_W-1:0]  cid;
        logic [MASK_W-1:0] mask;
        pick = $urandom_range(99);
        if      (pick < 10) op = OP_CREATE;
        else if (pick < 25) op = OP_ALIVE;
        else if (pick < 33) op = OP_KILL;
        else if (pick < 47) op = OP_HAS1;
        else if (pick < 61) op = OP_HASALL;
        else if (pick < 78) op = OP_SETMAP;
        else if (pick < 98) op = OP_QUERY;
        else                op = OP_UNKNOWN;
        slot = pick_slot();
        gen  = ($urandom_range(99) < 85) ? slot_gen[slot]
                                         : GEN_W'($urandom_range(16'hFFFF, 0));
        cid  = CID_W'($urandom_range(COMP_COUNT - 1, 0));
        pick = $urandom_range(99);
        case (op)
            OP_SETMAP: begin
                if      (pick < 50) mask = rand_word() & rand_word() & rand_word();
                else if (pick < 90) mask = rand_word();
                else if (pick < 95) mask = '1;
                else                mask = '0;
            end
            OP_QUERY: begin
                if ($urandom_range(1) == 0) slot = '0;
                if      (pick < 60) mask = slot_map[pick_slot()] & rand_word();
                else if (pick < 75) mask = '0;
                else                mask = rand_word() & rand_word() & rand_word();
            end
            default: begin
                if      (pick < 60) mask = slot_map[slot] & rand_word();
                else if (pick < 80) mask = '0;
                else                mask = rand_word();
            end
        endcase
        send_request(op, slot, gen, cid, mask);
    endtask

    // Extremes, every operation, reserved slot, dead and destroyed handles,
    // query past the last slot and the undecoded operation.
    task automatic test_directed();
        send_request(OP_QUERY,   10'd0,    16'd0,      6'd0,  '0);
        send_request(OP_CREATE,  10'd0,    16'd0,      6'd0,  '0);
        send_request(OP_CREATE,  10'd1023, 16'hFFFF,   6'd63, '1);
        send_request(OP_CREATE,  10'd0,    16'd0,      6'd0,  '0);
        send_request(OP_ALIVE,   10'd1,    16'd1,      6'd0,  '0);
        send_request(OP_ALIVE,   10'd1,    16'hFFFF,   6'd0,  '0);
        send_request(OP_ALIVE,   10'd0,    16'd0,      6'd0,  '0);
        send_request(OP_SETMAP,  10'd1,    16'd0,      6'd0,  '1);
        send_request(OP_SETMAP,  10'd2,    16'd0,      6'd0,  64'h8000_0000_0000_0001);
        send_request(OP_HAS1,    10'd1,    16'd1,      6'd63, '0);
        send_request(OP_HAS1,    10'd2,    16'd1,      6'd0,  '0);
        send_request(OP_HAS1,    10'd2,    16'd1,      6'd1,  '0);
        send_request(OP_HASALL,  10'd2,    16'd1,      6'd0,  '1);
        send_request(OP_HASALL,  10'd1,    16'd1,      6'd0,  '1);
        send_request(OP_QUERY,   10'd0,    16'd0,      6'd0,  64'h8000_0000_0000_0000);
        send_request(OP_QUERY,   10'd1,    16'd0,      6'd0,  '1);
        send_request(OP_QUERY,   10'd1023, 16'd0,      6'd0,  '0);
        send_request(OP_KILL,    10'd2,    16'd0,      6'd0,  '0);
        send_request(OP_ALIVE,   10'd2,    16'd1,      6'd0,  '0);
        send_request(OP_HAS1,    10'd2,    16'd1,      6'd0,  '0);
        send_request(OP_SETMAP,  10'd1023, 16'd0,      6'd0,  '1);
        send_request(OP_QUERY,   10'd0,    16'd0,      6'd0,  '0);
        send_request(OP_UNKNOWN, 10'd1023, 16'hFFFF,   6'd63, '1);
        send_request(OP_HASALL,  10'd3,    16'd1,      6'd0,  '0);
        wait_drain();
    endtask

    task automatic test_random_mix();
        repeat (220) random_request();
    endtask

    // Response side held off while requests keep coming: the block fills and
    // must stall its input without losing or reordering anything.
    task automatic test_backpressure();
        rsp_hold = 400;
        repeat (40) random_request();
        wait_drain();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (100) random_request();
        no_idle = 1'b0;
    endtask

    // Burst of creates with junk in the unused fields, then more traffic
    // over the grown table, including longer scans.
    task automatic test_create_burst();
        repeat (40)
            send_request(OP_CREATE, SLOT_W'($urandom_range(1023, 0)),
                         GEN_W'($urandom_range(16'hFFFF, 0)),
                         CID_W'($urandom_range(63, 0)), rand_word());
        repeat (30) random_request();
    endtask

    initial begin
        i_clk                       = 1'b0;
        i_rst_n                     = 1'b0;
        req_if.valid                = 1'b0;
        req_if.operation            = '0;
        req_if.slot_index           = '0;
        req_if.handle_generation    = '0;
        req_if.component_id         = '0;
        req_if.component_mask       = '0;
        mismatch_count              = 0;
        rsp_hold                    = 0;
        no_idle                     = 1'b0;
        table_used                  = 1;
        foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_gen[i]  = '0;
            slot_map[i]  = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_mix();
        test_backpressure();
        test_back_to_back();
        test_create_burst();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: well beyond the worst case of full-table scans under stalls.
    initial begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
